/* rtl/argp_pkg.sv */
// argp_pkg: shared types, widths and helpers for the argsort permutation block
// no dependencies; used by all files in rtl/

package argp_pkg;

    localparam int MAX_N      = 64;
    localparam int VALUE_BITS = 32;
    localparam int IN_W       = 32;
    localparam int POS_W      = 6;
    localparam int IDX_W      = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CNT_W      = $clog2(MAX_N + 1);

    typedef logic signed [VALUE_BITS-1:0] t_key;
    typedef logic [IDX_W-1:0]             t_idx;
    typedef logic [CNT_W-1:0]             t_cnt;

    // one sorted element held in a cell
    typedef struct packed {
        t_key key;
        t_idx tag;
    } t_elem;

    // per-cycle command broadcast to the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_BUILD = 3'b010,
        ST_EMIT  = 3'b100
    } t_state;

    // size cast sign-extends or truncates the word to the key width
    function automatic t_key to_key(input logic signed [IN_W-1:0] value);
        to_key = VALUE_BITS'(value);
    endfunction

endpackage

/* rtl/argp_cell.sv */
// argp_cell: one cell of the sorted insertion chain
// depends on argp_pkg

module argp_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  argp_pkg::t_cell_ctrl i_ctrl,
    input  argp_pkg::t_elem     i_new,
    input  argp_pkg::t_elem     i_prev,
    input  logic                i_prev_valid,
    input  logic                i_prev_gt,
    input  argp_pkg::t_elem     i_next,
    input  logic                i_next_valid,
    output argp_pkg::t_elem     o_elem,
    output logic                o_valid,
    output logic                o_gt
);

    argp_pkg::t_elem r_elem;
    logic            r_valid;
    logic            take;

    // strictly greater keeps equal keys below the new word
    assign o_gt   = r_valid && (r_elem.key > i_new.key);
    assign take   = o_gt || (!r_valid && i_prev_valid);
    assign o_elem = r_elem;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_elem <= i_next;
        end else if (i_ctrl.insert && take) begin
            r_elem <= i_prev_gt ? i_prev : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_next_valid;
        end else if (i_ctrl.insert && take) begin
            r_valid <= 1'b1;
        end
    end

endmodule

/* rtl/argp_chain.sv */
// argp_chain: row of MAX_N insertion cells kept in ascending key order
// depends on argp_pkg and argp_cell

module argp_chain (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  argp_pkg::t_cell_ctrl i_ctrl,
    input  argp_pkg::t_elem      i_new,
    output argp_pkg::t_elem      o_head,
    output logic                 o_head_valid
);

    argp_pkg::t_elem elem  [argp_pkg::MAX_N];
    logic            valid [argp_pkg::MAX_N];
    logic            gt    [argp_pkg::MAX_N];

    for (genvar g = 0; g < argp_pkg::MAX_N; g++) begin : g_cell
        argp_pkg::t_elem prev_elem;
        argp_pkg::t_elem next_elem;
        logic            prev_valid;
        logic            prev_gt;
        logic            next_valid;

        if (g == 0) begin : g_first
            assign prev_elem  = i_new;
            assign prev_valid = 1'b1;
            assign prev_gt    = 1'b0;
        end else begin : g_mid
            assign prev_elem  = elem[g-1];
            assign prev_valid = valid[g-1];
            assign prev_gt    = gt[g-1];
        end

        if (g == argp_pkg::MAX_N - 1) begin : g_last
            assign next_elem  = i_new;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_elem  = elem[g+1];
            assign next_valid = valid[g+1];
        end

        argp_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (i_ctrl),
            .i_new        (i_new),
            .i_prev       (prev_elem),
            .i_prev_valid (prev_valid),
            .i_prev_gt    (prev_gt),
            .i_next       (next_elem),
            .i_next_valid (next_valid),
            .o_elem       (elem[g]),
            .o_valid      (valid[g]),
            .o_gt         (gt[g])
        );
    end

    assign o_head       = elem[0];
    assign o_head_valid = valid[0];

endmodule

/* rtl/argp_perm_store.sv */
// argp_perm_store: forward and inverse permutation memories with registered read
// depends on argp_pkg

module argp_perm_store (
    input  logic           i_clk,
    input  logic           i_wr_en,
    input  argp_pkg::t_idx i_wr_pos,
    input  argp_pkg::t_idx i_wr_tag,
    input  logic           i_rd_en,
    input  argp_pkg::t_idx i_rd_addr,
    output argp_pkg::t_idx o_src_q,
    output argp_pkg::t_idx o_rank_q
);

    argp_pkg::t_idx fwd_mem [argp_pkg::MAX_N];
    argp_pkg::t_idx inv_mem [argp_pkg::MAX_N];
    argp_pkg::t_idx r_src_q;
    argp_pkg::t_idx r_rank_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            fwd_mem[i_wr_pos] <= i_wr_tag;
            inv_mem[i_wr_tag] <= i_wr_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_src_q  <= fwd_mem[i_rd_addr];
            r_rank_q <= inv_mem[i_rd_addr];
        end
    end

    assign o_src_q  = r_src_q;
    assign o_rank_q = r_rank_q;

endmodule

/* rtl/argsort_permutation.sv */
// argsort_permutation: stable argsort of a signed vector with inverse permutation
// top level; depends on argp_pkg, argp_chain and argp_perm_store
//
// input channel (i_valid / o_ready): one word per element, i_value is the sort
// key, i_last ends the vector. o_ready is high while loading, so elements are
// taken one per cycle; each is inserted into a chain of MAX_N cells as it is
// taken. Words past MAX_N are dropped and set the overflow flag.
// after the last word, the chain is drained into the permutation memories,
// one position per cycle, one for each loaded element, with o_ready low.
// output channel (o_valid / i_ready): n result words follow the drain, one per cycle
// while the receiver takes them. each word carries the position, the source index
// at that position, the rank of the element whose source index is that position,
// the overflow flag and o_last_out on the final word. the output register holds
// its word while i_ready is low and the memory read waits with it.
// after the final word is taken the block returns to loading with count and
// overflow cleared. reset empties the chain and goes to loading.

module argsort_permutation (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [argp_pkg::IN_W-1:0]    i_value,
    input  logic                         i_last,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [argp_pkg::POS_W-1:0]   o_position,
    output logic [argp_pkg::POS_W-1:0]   o_source_index,
    output logic [argp_pkg::POS_W-1:0]   o_rank,
    output logic                         o_overflow,
    output logic                         o_last_out
);

    argp_pkg::t_state     r_state, n_state;
    argp_pkg::t_cnt       r_count, n_count;
    logic                 r_overflow, n_overflow;
    argp_pkg::t_idx       r_build_pos, n_build_pos;
    argp_pkg::t_cnt       r_rd_ptr, n_rd_ptr;
    logic                 r_out_valid, n_out_valid;
    argp_pkg::t_idx       r_out_pos, n_out_pos;
    logic                 r_out_last, n_out_last;

    argp_pkg::t_cell_ctrl ctrl;
    argp_pkg::t_elem      new_elem;
    argp_pkg::t_elem      head;
    logic                 head_valid;
    logic                 in_take;
    logic                 has_room;
    logic                 rd_load;
    logic                 out_take;
    argp_pkg::t_idx       src_q;
    argp_pkg::t_idx       rank_q;

    assign o_ready  = (r_state == argp_pkg::ST_LOAD);
    assign in_take  = i_valid && o_ready;
    assign has_room = (r_count != argp_pkg::CNT_W'(argp_pkg::MAX_N));
    assign out_take = r_out_valid && i_ready;
    // refill the output register when it is empty or being taken
    assign rd_load  = (r_state == argp_pkg::ST_EMIT) && (r_rd_ptr < r_count)
                      && (!r_out_valid || i_ready);

    assign new_elem.key = argp_pkg::to_key(i_value);
    assign new_elem.tag = argp_pkg::IDX_W'(r_count);
    assign ctrl.insert  = in_take && has_room;
    assign ctrl.shift   = (r_state == argp_pkg::ST_BUILD);

    argp_chain u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_new        (new_elem),
        .o_head       (head),
        .o_head_valid (head_valid)
    );

    argp_perm_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ctrl.shift),
        .i_wr_pos  (r_build_pos),
        .i_wr_tag  (head.tag),
        .i_rd_en   (rd_load),
        .i_rd_addr (r_rd_ptr[argp_pkg::IDX_W-1:0]),
        .o_src_q   (src_q),
        .o_rank_q  (rank_q)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_overflow  = r_overflow;
        n_build_pos = r_build_pos;
        n_rd_ptr    = r_rd_ptr;
        n_out_valid = r_out_valid;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;
        unique case (r_state)
            argp_pkg::ST_LOAD: begin
                if (in_take) begin
                    if (has_room) begin
                        n_count = r_count + argp_pkg::CNT_W'(1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                    if (i_last) begin
                        n_state     = argp_pkg::ST_BUILD;
                        n_build_pos = '0;
                    end
                end
            end
            argp_pkg::ST_BUILD: begin
                n_build_pos = r_build_pos + argp_pkg::IDX_W'(1);
                if (r_build_pos == argp_pkg::IDX_W'(r_count - argp_pkg::CNT_W'(1))) begin
                    n_state  = argp_pkg::ST_EMIT;
                    n_rd_ptr = '0;
                end
            end
            argp_pkg::ST_EMIT: begin
                if (rd_load) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = r_rd_ptr[argp_pkg::IDX_W-1:0];
                    n_out_last  = (r_rd_ptr + argp_pkg::CNT_W'(1) == r_count);
                    n_rd_ptr    = r_rd_ptr + argp_pkg::CNT_W'(1);
                end else if (out_take) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state    = argp_pkg::ST_LOAD;
                        n_count    = '0;
                        n_overflow = 1'b0;
                    end
                end
            end
            default: begin
                n_state = argp_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= argp_pkg::ST_LOAD;
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_build_pos <= n_build_pos;
        r_rd_ptr    <= n_rd_ptr;
        r_out_pos   <= n_out_pos;
        r_out_last  <= n_out_last;
    end

    assign o_valid        = r_out_valid;
    assign o_position     = argp_pkg::POS_W'(r_out_pos);
    assign o_source_index = argp_pkg::POS_W'(src_q);
    assign o_rank         = argp_pkg::POS_W'(rank_q);
    assign o_overflow     = r_overflow;
    assign o_last_out     = r_out_last;

    a_out_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == argp_pkg::ST_EMIT))
        else $error("result word outside emission");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= argp_pkg::CNT_W'(argp_pkg::MAX_N))
        else $error("element count beyond chain length");

    a_head_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == argp_pkg::ST_BUILD) |-> head_valid)
        else $error("chain drained past its last element");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |->
            (r_out_pos == argp_pkg::IDX_W'(r_count - argp_pkg::CNT_W'(1))))
        else $error("final word at wrong position");

    a_full_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> !has_room)
        else $error("overflow flagged with free cells");

endmodule

/* tb/sv/tb_argsort_permutation.sv */
// tb_argsort_permutation: self-checking testbench for the argsort permutation block
// drives vectors of signed keys, predicts the stable sort and inverse permutation,
// checks every result word in order; depends on argp_pkg and argsort_permutation
`timescale 1ns / 100ps

module tb_argsort_permutation;

    localparam int POS_W    = argp_pkg::POS_W;
    localparam int CHAIN_N  = argp_pkg::MAX_N;
    localparam int N_DIR    = 24;
    localparam int N_ITEMS  = 410;
    localparam int DRAIN_CY = 2 * CHAIN_N + 16;

    localparam logic [31:0] KEY_MIN = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] KEY_M1  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] source_index;
        logic [POS_W-1:0] rank;
        logic             overflow;
        logic             last_out;
    } t_perm_word;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
        logic        typed;
        t_perm_word  want;
    } t_stim_row;

    // a vector of one element sorts to itself
    localparam t_perm_word SOLO = '{6'd0, 6'd0, 6'd0, 1'b0, 1'b1};
    localparam t_perm_word NONE = '0;

    logic                    i_clk;
    logic                    i_rst_n        = 1'b0;
    logic                    i_valid        = 1'b0;
    logic [argp_pkg::IN_W-1:0] i_value      = '0;
    logic                    i_last         = 1'b0;
    logic                    i_ready        = 1'b0;
    logic                    o_ready;
    logic                    o_valid;
    logic [POS_W-1:0]        o_position;
    logic [POS_W-1:0]        o_source_index;
    logic [POS_W-1:0]        o_rank;
    logic                    o_overflow;
    logic                    o_last_out;

    argsort_permutation dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_position     (o_position),
        .o_source_index (o_source_index),
        .o_rank         (o_rank),
        .o_overflow     (o_overflow),
        .o_last_out     (o_last_out)
    );

    // predictor state: sorted chain of keys with their arrival tags
    argp_pkg::t_key   chain_key [CHAIN_N];
    logic [POS_W-1:0] chain_tag [CHAIN_N];
    int               held      = 0;
    bit               dropped   = 1'b0;

    t_perm_word perm_words_due[$];
    int         mismatches    = 0;
    int         send_idle_pct = 32;
    int         recv_idle_pct = 75;

    t_stim_row dir_rows [N_DIR] = '{
        '{KEY_MIN,       1'b1, 1'b1, SOLO},
        '{KEY_MAX,       1'b1, 1'b1, SOLO},
        '{32'd0,         1'b1, 1'b1, SOLO},
        '{KEY_M1,        1'b1, 1'b1, SOLO},
        // equal keys keep arrival order
        '{32'd7,         1'b0, 1'b0, NONE},
        '{32'd7,         1'b0, 1'b0, NONE},
        '{32'd7,         1'b0, 1'b0, NONE},
        '{32'd7,         1'b1, 1'b0, NONE},
        '{KEY_MAX,       1'b0, 1'b0, NONE},
        '{32'd100,       1'b0, 1'b0, NONE},
        '{32'd0,         1'b0, 1'b0, NONE},
        '{KEY_M1,        1'b0, 1'b0, NONE},
        '{KEY_MIN,       1'b1, 1'b0, NONE},
        '{KEY_MIN,       1'b0, 1'b0, NONE},
        '{KEY_M1,        1'b0, 1'b0, NONE},
        '{32'd0,         1'b0, 1'b0, NONE},
        '{32'd1,         1'b0, 1'b0, NONE},
        '{KEY_MAX,       1'b1, 1'b0, NONE},
        '{KEY_MIN,       1'b0, 1'b0, NONE},
        '{KEY_MAX,       1'b0, 1'b0, NONE},
        '{KEY_MIN,       1'b0, 1'b0, NONE},
        '{KEY_MAX,       1'b1, 1'b0, NONE},
        '{32'd3,         1'b0, 1'b0, NONE},
        '{32'hFFFF_FFFD, 1'b1, 1'b0, NONE}
    };

    // insert one element into the sorted chain; on last, rank every element
    function automatic void insert_and_rank(input logic [31:0] value, input logic last,
                                            ref t_perm_word words[$]);
        argp_pkg::t_key   k;
        logic [POS_W-1:0] rank_of [CHAIN_N];
        t_perm_word       w;
        int               p;
        k = argp_pkg::t_key'($signed(value));
        if (held < CHAIN_N) begin
            p = held;
            while (p > 0 && chain_key[p-1] > k) begin
                chain_key[p] = chain_key[p-1];
                chain_tag[p] = chain_tag[p-1];
                p--;
            end
            chain_key[p] = k;
            chain_tag[p] = POS_W'(held);
            held++;
        end else begin
            dropped = 1'b1;
        end
        if (!last)
            return;
        for (int i = 0; i < held; i++)
            rank_of[chain_tag[i]] = POS_W'(i);
        for (int i = 0; i < held; i++) begin
            w.position     = POS_W'(i);
            w.source_index = chain_tag[i];
            w.rank         = rank_of[i];
            w.overflow     = dropped;
            w.last_out     = (i == held - 1);
            words.push_back(w);
        end
        held    = 0;
        dropped = 1'b0;
    endfunction

    // present one word, wait for it to be taken, then queue what it causes
    task automatic send_word(input logic [31:0] value, input logic last,
                             input logic typed, input t_perm_word want);
        t_perm_word fresh[$];
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        i_last  <= last;
        do @(posedge i_clk); while (!o_ready);
        insert_and_rank(value, last, fresh);
        if (typed)
            perm_words_due.push_back(want);
        else
            foreach (fresh[j]) perm_words_due.push_back(fresh[j]);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_perm_word got;
        t_perm_word want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_position, o_source_index, o_rank, o_overflow, o_last_out};
            if (perm_words_due.size() == 0) begin
                $display("%0t: unexpected word pos=%0d src=%0d rank=%0d ovf=%0b last=%0b",
                         $time, got.position, got.source_index, got.rank, got.overflow,
                         got.last_out);
                mismatches++;
            end else begin
                want = perm_words_due.pop_front();
                if (got !== want) begin
                    $display("%0t: expected pos=%0d src=%0d rank=%0d ovf=%0b last=%0b",
                             $time, want.position, want.source_index, want.rank,
                             want.overflow, want.last_out);
                    $display("%0t: actual   pos=%0d src=%0d rank=%0d ovf=%0b last=%0b",
                             $time, got.position, got.source_index, got.rank,
                             got.overflow, got.last_out);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int          sent;
        int          run_no;
        int          len;
        logic [31:0] v;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r])
            send_word(dir_rows[r].value, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].want);

        sent   = N_DIR;
        run_no = 0;
        while (sent < N_ITEMS) begin
            if (sent >= 250) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (sent >= 130) begin
                send_idle_pct = 75;
                recv_idle_pct = 32;
            end
            // mostly short vectors, now and then a full chain or one that overflows
            case (run_no % 12)
                5:       len = $urandom_range(CHAIN_N + 4, CHAIN_N);
                9:       len = $urandom_range(CHAIN_N, 20);
                default: len = $urandom_range(8, 1);
            endcase
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: v = $urandom;
                    5, 6, 7:       v = 32'($urandom_range(7)) - 32'd4;
                    default: begin
                        case ($urandom_range(3))
                            0:       v = KEY_MIN;
                            1:       v = KEY_MAX;
                            2:       v = 32'd0;
                            default: v = KEY_M1;
                        endcase
                    end
                endcase
                send_word(v, (k == len - 1), 1'b0, NONE);
            end
            sent += len;
            run_no++;
        end
        i_valid <= 1'b0;

        while (perm_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CY) @(posedge i_clk);
        if (mismatches == 0 && perm_words_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
rtl/argp_pkg.sv
rtl/argp_cell.sv
rtl/argp_chain.sv
rtl/argp_perm_store.sv
rtl/argsort_permutation.sv
tb/sv/tb_argsort_permutation.sv
